// File: src/dtq_pkg.sv
// Shared types and constants of the deadline timer queue.
`timescale 1ns / 1ps

package dtq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int MAX_RESULTS         = 16;
   localparam int POP_CNT_W           = $clog2(MAX_RESULTS);
   localparam int DEADLINE_W          = 64;
   localparam int HANDLE_W            = 8;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam logic STATUS_FIRED  = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic insert;
      logic latch_now;
      logic load_reject;
      logic fire;
      logic last;
   } dtq_cmd_type;

   typedef struct packed {
      logic full;
      logic head_due;
      logic next_due;
   } dtq_status_type;

endpackage

// File: src/dtq_ctrl.sv
// Controller state machine of the deadline timer queue.
`timescale 1ns / 1ps

module dtq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  dtq_pkg::dtq_status_type status,
   output dtq_pkg::dtq_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_POP  = 1'b1;

   logic                          state_ff, state_in;
   logic [dtq_pkg::POP_CNT_W-1:0] pop_cnt_ff, pop_cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_free;
   logic                          accept;
   logic                          last_pop;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // The final pop of a tick is the one after which the new head is not due,
   // or the one that reaches the per-tick result limit.
   assign last_pop = !status.next_due ||
                     (pop_cnt_ff == dtq_pkg::POP_CNT_W'(dtq_pkg::MAX_RESULTS - 1));

   always_comb begin
      cmd.insert      = accept && (req_mode == dtq_pkg::MODE_ADD) && !status.full;
      cmd.load_reject = accept && (req_mode == dtq_pkg::MODE_ADD) && status.full;
      cmd.latch_now   = accept && (req_mode == dtq_pkg::MODE_TICK);
      cmd.fire        = (state_ff == ST_POP) && status.head_due && out_free;
      cmd.last        = cmd.load_reject || last_pop;
   end

   always_comb begin
      state_in   = state_ff;
      pop_cnt_in = pop_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.latch_now) begin
               state_in   = ST_POP;
               pop_cnt_in = '0;
            end
         end
         ST_POP: begin
            if (!status.head_due) begin
               state_in = ST_IDLE;
            end else if (cmd.fire) begin
               pop_cnt_in = pop_cnt_ff + 1'b1;
               if (last_pop) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_reject || cmd.fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pop_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pop_cnt_ff   <= pop_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/dtq_datapath.sv
// Datapath of the deadline timer queue: sorted cell row, tick time and result word.
`timescale 1ns / 1ps

module dtq_datapath #(
   parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [dtq_pkg::DEADLINE_W-1:0]  req_deadline,
   input  logic [dtq_pkg::HANDLE_W-1:0]    req_handle,
   input  logic [dtq_pkg::DEADLINE_W-1:0]  req_now_time,
   input  dtq_pkg::dtq_cmd_type            cmd,
   output dtq_pkg::dtq_status_type         status,
   output logic                            rsp_status,
   output logic [dtq_pkg::HANDLE_W-1:0]    rsp_fired_handle,
   output logic [dtq_pkg::DEADLINE_W-1:0]  rsp_fired_deadline,
   output logic                            rsp_last
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [dtq_pkg::DEADLINE_W-1:0] deadline_ff [QUEUE_DEPTH];
   logic [dtq_pkg::DEADLINE_W-1:0] deadline_in [QUEUE_DEPTH];
   logic [dtq_pkg::HANDLE_W-1:0]   handle_ff   [QUEUE_DEPTH];
   logic [dtq_pkg::HANDLE_W-1:0]   handle_in   [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]         keep;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [dtq_pkg::DEADLINE_W-1:0] now_ff;

   logic                           status_ff;
   logic [dtq_pkg::HANDLE_W-1:0]   fired_handle_ff;
   logic [dtq_pkg::DEADLINE_W-1:0] fired_deadline_ff;
   logic                           last_ff;

   assign status.full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.head_due = (count_ff != '0) && (deadline_ff[0] <= now_ff);
   assign status.next_due = (count_ff > CNT_W'(1)) && (deadline_ff[1] <= now_ff);

   // A cell keeps its entry on insertion when it holds a timer that is not later
   // than the new one; the kept cells form a prefix because the row is sorted.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         keep[i] = (count_ff > CNT_W'(i)) && (deadline_ff[i] <= req_deadline);
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         deadline_in[i] = deadline_ff[i];
         handle_in[i]   = handle_ff[i];
         if (cmd.insert) begin
            if (!keep[i]) begin
               if (i == 0) begin
                  deadline_in[i] = req_deadline;
                  handle_in[i]   = req_handle;
               end else if (keep[i-1]) begin
                  deadline_in[i] = req_deadline;
                  handle_in[i]   = req_handle;
               end else begin
                  deadline_in[i] = deadline_ff[i-1];
                  handle_in[i]   = handle_ff[i-1];
               end
            end
         end else if (cmd.fire) begin
            if (i < QUEUE_DEPTH - 1) begin
               deadline_in[i] = deadline_ff[i+1];
               handle_in[i]   = handle_ff[i+1];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         deadline_ff[i] <= deadline_in[i];
         handle_ff[i]   <= handle_in[i];
      end
      if (cmd.latch_now) begin
         now_ff <= req_now_time;
      end
      if (cmd.load_reject) begin
         status_ff         <= dtq_pkg::STATUS_REJECT;
         fired_handle_ff   <= req_handle;
         fired_deadline_ff <= req_deadline;
         last_ff           <= cmd.last;
      end else if (cmd.fire) begin
         status_ff         <= dtq_pkg::STATUS_FIRED;
         fired_handle_ff   <= handle_ff[0];
         fired_deadline_ff <= deadline_ff[0];
         last_ff           <= cmd.last;
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_fired_handle   = fired_handle_ff;
   assign rsp_fired_deadline = fired_deadline_ff;
   assign rsp_last           = last_ff;

endmodule

// File: src/deadline_timer_queue.sv
// Top level of the deadline timer queue.
`timescale 1ns / 1ps

// A bounded queue of timers kept sorted by deadline; equal deadlines keep
// their arrival order. Request words (req_) either add a timer (deadline and
// handle) or carry the current time as a tick. Result words (rsp_) report a
// fired timer, or an add rejected because the queue holds QUEUE_DEPTH timers.
// On an add, the sorted row of cells compares every entry against the new
// deadline in parallel and shifts the later ones up at the accepting edge.
// A tick latches the time and then pops one due timer per cycle from the
// head while the result register is free, at most 16 per tick, the last one
// marked by rsp_last; a tick with nothing due still looks at the head.
// The cell row pops a single entry at a time. No new request is taken while
// a tick pops. Results pass through one output register; while a word waits
// there with rsp_ready low, the pop sequence waits and req_ready stays low.
// Reset empties the queue and drops any pending result word.

module deadline_timer_queue #(
   parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic [dtq_pkg::DEADLINE_W-1:0] req_deadline,
   input  logic [dtq_pkg::HANDLE_W-1:0]   req_handle,
   input  logic [dtq_pkg::DEADLINE_W-1:0] req_now_time,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_status,
   output logic [dtq_pkg::HANDLE_W-1:0]   rsp_fired_handle,
   output logic [dtq_pkg::DEADLINE_W-1:0] rsp_fired_deadline,
   output logic                           rsp_last
);

   dtq_pkg::dtq_cmd_type    cmd;
   dtq_pkg::dtq_status_type status;

   dtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dtq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_deadline       (req_deadline),
      .req_handle         (req_handle),
      .req_now_time       (req_now_time),
      .cmd                (cmd),
      .status             (status),
      .rsp_status         (rsp_status),
      .rsp_fired_handle   (rsp_fired_handle),
      .rsp_fired_deadline (rsp_fired_deadline),
      .rsp_last           (rsp_last)
   );

   // A rejected add is always a single, final word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dtq_pkg::STATUS_REJECT) |-> rsp_last)
      else $error("rejected add word without last marker");

   // An add that finds the queue full is answered by a reject word next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == dtq_pkg::MODE_ADD) && status.full
      |=> rsp_valid && (rsp_status == dtq_pkg::STATUS_REJECT))
      else $error("full queue did not reject an add");

   // A tick blocks further requests while it examines the head.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == dtq_pkg::MODE_TICK) |=> !req_ready)
      else $error("request taken while a tick is in progress");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the deadline timer queue.
`timescale 1ns / 1ps

module tb_top;
   import dtq_pkg::*;

   localparam int DEPTH       = QUEUE_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic                  mode;
      logic [DEADLINE_W-1:0] deadline;
      logic [HANDLE_W-1:0]   handle;
      logic [DEADLINE_W-1:0] now_time;
   } timer_request_type;

   typedef struct {
      logic                  status;
      logic [HANDLE_W-1:0]   handle;
      logic [DEADLINE_W-1:0] deadline;
      logic                  last;
   } fired_timer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_mode = MODE_ADD;
   logic [DEADLINE_W-1:0] req_deadline = '0;
   logic [HANDLE_W-1:0]   req_handle = '0;
   logic [DEADLINE_W-1:0] req_now_time = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_status;
   logic [HANDLE_W-1:0]   rsp_fired_handle;
   logic [DEADLINE_W-1:0] rsp_fired_deadline;
   logic                  rsp_last;

   timer_request_type     timer_requests[$];
   fired_timer_type       due_results[$];

   // Shadow copy of the sorted timer row, head at index 0.
   logic [DEADLINE_W-1:0] shadow_deadline[DEPTH];
   logic [HANDLE_W-1:0]   shadow_handle[DEPTH];
   int                    shadow_count = 0;

   int                    fail_count = 0;
   int                    cycle_count = 0;
   int                    req_wait = 0;
   int                    rsp_wait = 0;
   logic                  req_up;

   deadline_timer_queue i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_deadline       (req_deadline),
      .req_handle         (req_handle),
      .req_now_time       (req_now_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_fired_handle   (rsp_fired_handle),
      .rsp_fired_deadline (rsp_fired_deadline),
      .rsp_last           (rsp_last)
   );

   always #2 clock = ~clock;

   // Idle gaps are switched off while bit 9 of the cycle counter is set.
   function automatic int idle_cycles();
      if (cycle_count[9]) return 0;
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [DEADLINE_W-1:0] any_time();
      return {$urandom, $urandom};
   endfunction

   // Updates the shadow row with one accepted request word and queues what it fires.
   function automatic void apply_timer_request(timer_request_type w);
      int              pos;
      int              n;
      fired_timer_type r;
      pos = 0;
      n   = 0;
      if (w.mode == MODE_ADD) begin
         if (shadow_count >= DEPTH) begin
            r = '{STATUS_REJECT, w.handle, w.deadline, 1'b1};
            due_results.push_back(r);
            return;
         end
         while (pos < shadow_count && shadow_deadline[pos] <= w.deadline) pos++;
         for (int k = shadow_count; k > pos; k--) begin
            shadow_deadline[k] = shadow_deadline[k-1];
            shadow_handle[k]   = shadow_handle[k-1];
         end
         shadow_deadline[pos] = w.deadline;
         shadow_handle[pos]   = w.handle;
         shadow_count++;
      end else begin
         while (n < shadow_count && n < MAX_RESULTS && shadow_deadline[n] <= w.now_time) n++;
         for (int k = 0; k < n; k++) begin
            r = '{STATUS_FIRED, shadow_handle[k], shadow_deadline[k], k == n - 1};
            due_results.push_back(r);
         end
         for (int k = 0; k + n < shadow_count; k++) begin
            shadow_deadline[k] = shadow_deadline[k+n];
            shadow_handle[k]   = shadow_handle[k+n];
         end
         shadow_count -= n;
      end
   endfunction

   function automatic void add_timer(logic [DEADLINE_W-1:0] dl, logic [HANDLE_W-1:0] h);
      timer_requests.push_back('{MODE_ADD, dl, h, any_time()});
   endfunction

   function automatic void tick_at(logic [DEADLINE_W-1:0] now);
      timer_requests.push_back('{MODE_TICK, any_time(), HANDLE_W'($urandom), now});
   endfunction

   // Request driver: one word at a time, each preceded by a drawn gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_wait   = idle_cycles();
      end else begin
         req_up = req_valid;
         if (req_valid && req_ready) begin
            apply_timer_request(timer_requests.pop_front());
            req_up   = 1'b0;
            req_wait = idle_cycles();
         end
         if (!req_up && timer_requests.size() != 0) begin
            if (req_wait == 0) begin
               req_up = 1'b1;
               req_mode     <= timer_requests[0].mode;
               req_deadline <= timer_requests[0].deadline;
               req_handle   <= timer_requests[0].handle;
               req_now_time <= timer_requests[0].now_time;
            end else begin
               req_wait--;
            end
         end
         req_valid <= req_up;
      end
   end

   // Result monitor: checks each accepted word, then stalls for a drawn number of cycles.
   always @(posedge clock) begin
      fired_timer_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("unexpected result word: handle %0d deadline %0h",
                      rsp_fired_handle, rsp_fired_deadline);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_fired_handle !== want.handle) begin
                  $error("fired_handle: expected %0d, got %0d", want.handle, rsp_fired_handle);
                  fail_count++;
               end
               if (rsp_fired_deadline !== want.deadline) begin
                  $error("fired_deadline: expected %0h, got %0h",
                         want.deadline, rsp_fired_deadline);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  fail_count++;
               end
            end
            rsp_wait = idle_cycles();
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("deadline_timer_queue: mismatch");
         $finish;
      end
   end

   initial begin
      logic [DEADLINE_W-1:0] base;
      logic [DEADLINE_W-1:0] value;
      int                    pick;
      int                    tick_pct;

      // Directed words: extreme values, insertion ahead of the head, a tie with the tail,
      // a tick with nothing due, a tick on an empty queue, a full queue and a long pop run.
      add_timer('1, 8'hFF);
      add_timer('0, 8'h00);
      add_timer(64'd50, 8'h01);
      add_timer('1, 8'h03);
      tick_at('0);
      tick_at(64'd49);
      tick_at('1);
      tick_at('1);
      for (int k = 0; k < DEPTH; k++) add_timer(64'd100 + (k * 7) % 5, HANDLE_W'(k + 16));
      add_timer('1, 8'hA5);
      tick_at('1);

      // Random words: alternating stretches that mostly add (filling the queue) and that
      // tick often, with deadlines clustered near a slowly advancing time.
      base = 64'd1000;
      for (int i = 0; i < 350; i++) begin
         tick_pct = ((i / 40) % 2 != 0) ? 45 : 10;
         pick     = $urandom_range(0, 19);
         if ($urandom_range(0, 99) < tick_pct) begin
            case (pick)
               0:       value = '1;
               1:       value = any_time();
               2:       value = '0;
               default: value = base + $urandom_range(0, 24);
            endcase
            tick_at(value);
            base += $urandom_range(0, 12);
         end else begin
            case (pick)
               0:       value = any_time();
               1:       value = '1;
               2:       value = '0;
               default: value = base + $urandom_range(0, 30);
            endcase
            add_timer(value, HANDLE_W'($urandom));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (timer_requests.size() != 0 || req_valid) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (fail_count == 0) begin
         $display("deadline_timer_queue: match");
      end else begin
         $display("deadline_timer_queue: mismatch");
      end
      $finish;
   end

endmodule

// File: files.f
src/dtq_pkg.sv
src/dtq_ctrl.sv
src/dtq_datapath.sv
src/deadline_timer_queue.sv
tb/sv/tb_top.sv
